// ===== rtl/core/uartrb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, operation and status codes, and sizes for the UART ring buffers.
// No dependencies; every other file of the block depends on this package.
package uartrb_pkg;

   localparam int DEPTH = 8;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   typedef logic [2:0]       op_type;
   typedef logic [2:0]       status_type;
   typedef logic [7:0]       byte_type;
   typedef logic [3:0]       fill_type;
   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [LVL_W-1:0] level_type;

   localparam op_type OP_PUT      = 3'd0;
   localparam op_type OP_GET      = 3'd1;
   localparam op_type OP_TX_READY = 3'd2;
   localparam op_type OP_RECEIVED = 3'd3;
   localparam op_type OP_FLUSH_RX = 3'd4;
   localparam op_type OP_FLUSH_TX = 3'd5;

   localparam status_type ST_OK           = 3'd0;
   localparam status_type ST_TX_FULL      = 3'd1;
   localparam status_type ST_RX_EMPTY     = 3'd2;
   localparam status_type ST_NOTHING_SEND = 3'd3;
   localparam status_type ST_RX_OVERWRITE = 3'd4;

   localparam level_type LVL_FULL = LVL_W'(DEPTH);
   localparam ptr_type   PTR_LAST = PTR_W'(DEPTH - 1);

   // controller -> datapath
   typedef struct packed {
      logic load_item;
      logic execute;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_busy;
   } stat_type;

   function automatic ptr_type ptr_advance(ptr_type p);
      ptr_type nxt;
      nxt = (p == PTR_LAST) ? '0 : p + ptr_type'(1);
      return nxt;
   endfunction

endpackage

// ===== rtl/core/uartrb_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response items.
// Depends on uartrb_pkg for the payload types.
interface uartrb_req_if;
   logic                 valid;
   logic                 ready;
   uartrb_pkg::op_type   operation;
   uartrb_pkg::byte_type data_byte;

   modport source (output valid, operation, data_byte, input ready);
   modport sink   (input valid, operation, data_byte, output ready);
endinterface

interface uartrb_rsp_if;
   logic                   valid;
   logic                   ready;
   uartrb_pkg::status_type status;
   uartrb_pkg::byte_type   out_byte;
   logic                   send_valid;
   uartrb_pkg::fill_type   tx_fill;
   uartrb_pkg::fill_type   rx_fill;
   logic                   tx_irq_armed;

   modport source (output valid, status, out_byte, send_valid, tx_fill, rx_fill,
                   tx_irq_armed, input ready);
   modport sink   (input valid, status, out_byte, send_valid, tx_fill, rx_fill,
                   tx_irq_armed, output ready);
endinterface

// ===== rtl/core/uartrb_ctrl.sv =====
`timescale 1ns / 1ps
// Two-state sequencer: takes an item, then executes it once the result register is free.
// Depends on uartrb_pkg.
module uartrb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  uartrb_pkg::stat_type stat,
   output uartrb_pkg::cmd_type  cmd
);
   import uartrb_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.execute   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the previous result has been taken
            if (!stat.out_busy) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_exec_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> state_ff == S_EXEC)
      else $error("execute outside EXEC state");
   a_load_goes_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff == S_EXEC)
      else $error("load did not enter EXEC");
   a_no_exec_when_busy: assert property (@(posedge clock) disable iff (reset)
      stat.out_busy |-> !cmd.execute)
      else $error("execute while result register busy");

endmodule

// ===== rtl/core/uartrb_datapath.sv =====
`timescale 1ns / 1ps
// Ring buffer storage, pointers, levels, interrupt arm bit and the result register.
// Depends on uartrb_pkg and uartrb_channels (response interface).
module uartrb_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  uartrb_pkg::op_type   req_operation,
   input  uartrb_pkg::byte_type req_data_byte,
   input  uartrb_pkg::cmd_type  cmd,
   output uartrb_pkg::stat_type stat,
   uartrb_rsp_if.source         rsp_ch
);
   import uartrb_pkg::*;

   // captured item
   op_type    op_ff;
   byte_type  byte_ff;

   // buffer memories
   byte_type  tx_mem [DEPTH];
   byte_type  rx_mem [DEPTH];
   byte_type  tx_rdata_ff;
   byte_type  rx_rdata_ff;

   // pointers and levels
   ptr_type   tx_rd_ptr_ff, tx_rd_ptr_in, tx_wr_ptr_ff, tx_wr_ptr_in;
   ptr_type   rx_rd_ptr_ff, rx_rd_ptr_in, rx_wr_ptr_ff, rx_wr_ptr_in;
   level_type tx_level_ff, tx_level_in, rx_level_ff, rx_level_in;
   logic      irq_ff, irq_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   status_type status_ff, status_in;
   byte_type   out_byte_ff, out_byte_in;
   logic       send_ff, send_in;

   logic tx_we, rx_we;

   assign stat.out_busy = out_valid_ff && !rsp_ch.ready;

   always_comb begin
      tx_rd_ptr_in = tx_rd_ptr_ff;
      tx_wr_ptr_in = tx_wr_ptr_ff;
      rx_rd_ptr_in = rx_rd_ptr_ff;
      rx_wr_ptr_in = rx_wr_ptr_ff;
      tx_level_in  = tx_level_ff;
      rx_level_in  = rx_level_ff;
      irq_in       = irq_ff;
      status_in    = ST_OK;
      out_byte_in  = '0;
      send_in      = 1'b0;
      tx_we        = 1'b0;
      rx_we        = 1'b0;
      if (cmd.execute) begin
         case (op_ff)
            OP_PUT: begin
               if (tx_level_ff == LVL_FULL) begin
                  status_in = ST_TX_FULL;
               end else begin
                  tx_we        = 1'b1;
                  tx_wr_ptr_in = ptr_advance(tx_wr_ptr_ff);
                  tx_level_in  = tx_level_ff + level_type'(1);
                  irq_in       = 1'b1;
               end
            end
            OP_GET: begin
               if (rx_level_ff == '0) begin
                  status_in = ST_RX_EMPTY;
               end else begin
                  out_byte_in  = rx_rdata_ff;
                  rx_rd_ptr_in = ptr_advance(rx_rd_ptr_ff);
                  rx_level_in  = rx_level_ff - level_type'(1);
               end
            end
            OP_TX_READY: begin
               if (tx_level_ff == '0) begin
                  status_in = ST_NOTHING_SEND;
               end else begin
                  out_byte_in  = tx_rdata_ff;
                  send_in      = 1'b1;
                  tx_rd_ptr_in = ptr_advance(tx_rd_ptr_ff);
               end
               // disarm once the queue drains (or was already empty)
               if (tx_level_ff <= level_type'(1)) begin
                  irq_in = 1'b0;
               end
               if (tx_level_ff != '0) begin
                  tx_level_in = tx_level_ff - level_type'(1);
               end
            end
            OP_RECEIVED: begin
               rx_we        = 1'b1;
               rx_wr_ptr_in = ptr_advance(rx_wr_ptr_ff);
               if (rx_level_ff == LVL_FULL) begin
                  rx_rd_ptr_in = ptr_advance(rx_rd_ptr_ff);
                  status_in    = ST_RX_OVERWRITE;
               end else begin
                  rx_level_in = rx_level_ff + level_type'(1);
               end
            end
            OP_FLUSH_RX: begin
               rx_rd_ptr_in = '0;
               rx_wr_ptr_in = '0;
               rx_level_in  = '0;
            end
            OP_FLUSH_TX: begin
               tx_rd_ptr_in = '0;
               tx_wr_ptr_in = '0;
               tx_level_in  = '0;
            end
            default: ;
         endcase
      end
      if (cmd.execute) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // memories: one write port, registered read at the head pointer
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wr_ptr_ff] <= byte_ff;
      end
      tx_rdata_ff <= tx_mem[tx_rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wr_ptr_ff] <= byte_ff;
      end
      rx_rdata_ff <= rx_mem[rx_rd_ptr_ff];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_operation;
         byte_ff <= req_data_byte;
      end
      if (cmd.execute) begin
         status_ff   <= status_in;
         out_byte_ff <= out_byte_in;
         send_ff     <= send_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_rd_ptr_ff <= '0;
         tx_wr_ptr_ff <= '0;
         rx_rd_ptr_ff <= '0;
         rx_wr_ptr_ff <= '0;
         tx_level_ff  <= '0;
         rx_level_ff  <= '0;
         irq_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tx_rd_ptr_ff <= tx_rd_ptr_in;
         tx_wr_ptr_ff <= tx_wr_ptr_in;
         rx_rd_ptr_ff <= rx_rd_ptr_in;
         rx_wr_ptr_ff <= rx_wr_ptr_in;
         tx_level_ff  <= tx_level_in;
         rx_level_ff  <= rx_level_in;
         irq_ff       <= irq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // fills and arm bit always reflect the state left by the last executed item
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.out_byte     = out_byte_ff;
   assign rsp_ch.send_valid   = send_ff;
   assign rsp_ch.tx_fill      = fill_type'(tx_level_ff);
   assign rsp_ch.rx_fill      = fill_type'(rx_level_ff);
   assign rsp_ch.tx_irq_armed = irq_ff;

   a_tx_level_bound: assert property (@(posedge clock) disable iff (reset)
      tx_level_ff <= LVL_FULL)
      else $error("tx level above depth");
   a_rx_level_bound: assert property (@(posedge clock) disable iff (reset)
      rx_level_ff <= LVL_FULL)
      else $error("rx level above depth");
   a_send_is_ok: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && send_ff) |-> status_ff == ST_OK)
      else $error("send flagged on a failed item");
   a_empty_tx_disarmed: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && op_ff == OP_TX_READY && tx_level_ff <= level_type'(1)) |=> !irq_ff)
      else $error("interrupt still armed after tx drained");

endmodule

// ===== rtl/core/uart_tx_rx_ring_buffers_unit.sv =====
`timescale 1ns / 1ps
// Top level of the UART transmit/receive ring buffers.
// Depends on uartrb_pkg, uartrb_channels, uartrb_ctrl and uartrb_datapath.
//
// Usage:
//   req_ch  (sink)   : one item per operation - put, get, transmitter ready,
//                      byte received, flush rx, flush tx - with its data byte.
//   rsp_ch  (source) : exactly one result item per request: status, returned
//                      byte, send flag, both fill levels and the tx irq arm bit.
//   A request is first captured into the item registers while each buffer's
//   memory presents its head byte; once the result register is free it is
//   executed, which updates pointers/levels and loads the result register. A
//   new item is not accepted until the previous one has been executed.
//   The block accepts a new item while the previous result still waits; that
//   item then waits in its execute cycle until the result is taken, so a
//   stalled receiver holds at most one extra item and nothing is lost.
//   Reset (synchronous, active high) empties both queues, disarms the tx
//   interrupt and drops any pending result; buffer contents are not cleared,
//   no clearing pass is needed since only queued entries are ever read.
//   Unused operation codes return status OK and change nothing.
module uart_tx_rx_ring_buffers_unit (
   input  logic        clock,
   input  logic        reset,
   uartrb_req_if.sink   req_ch,
   uartrb_rsp_if.source rsp_ch
);
   import uartrb_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_ch.ready = req_ready;

   // sequencer: item capture and execute timing
   uartrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // buffers, pointers and result register
   uartrb_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_ch.operation),
      .req_data_byte (req_ch.data_byte),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ch        (rsp_ch)
   );

endmodule
